@@ rtl/ccp_pkg.sv @@
// ccp_pkg: shared types, codes and tag helpers for the constant pool parser
// used by ccp_front, ccp_queue, ccp_back and class_constant_pool_parser
`timescale 1ns / 1ps

package ccp_pkg;

  // constant pool tag bytes
  localparam logic [7:0] TAG_UTF8      = 8'd1;
  localparam logic [7:0] TAG_INTEGER   = 8'd3;
  localparam logic [7:0] TAG_FLOAT     = 8'd4;
  localparam logic [7:0] TAG_LONG      = 8'd5;
  localparam logic [7:0] TAG_DOUBLE    = 8'd6;
  localparam logic [7:0] TAG_CLASS     = 8'd7;
  localparam logic [7:0] TAG_STRING    = 8'd8;
  localparam logic [7:0] TAG_FIELDREF  = 8'd9;
  localparam logic [7:0] TAG_METHODREF = 8'd10;
  localparam logic [7:0] TAG_IMETHREF  = 8'd11;
  localparam logic [7:0] TAG_NAMETYPE  = 8'd12;

  // parser phase, one-hot
  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_COUNT = 7'b0000010,
    PH_TAG   = 7'b0000100,
    PH_BODY  = 7'b0001000,
    PH_TEXT  = 7'b0010000,
    PH_DONE  = 7'b0100000,
    PH_HALT  = 7'b1000000
  } ccp_phase_t;

  // kind of record passed from front to back
  typedef enum logic [1:0] {
    REC_POOL  = 2'd0,
    REC_BAD   = 2'd1,
    REC_ENTRY = 2'd2,
    REC_TEXT  = 2'd3
  } ccp_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_pool;
  } ccp_in_t;

  typedef struct packed {
    logic        entry_done;
    logic [15:0] entry_index;
    logic [7:0]  tag_code;
    logic [63:0] const_value;
    logic [15:0] first_ref;
    logic [15:0] second_ref;
    logic        text_valid;
    logic [7:0]  text_byte;
    logic        pool_done;
    logic [31:0] bytes_consumed;
    logic        bad_tag;
  } ccp_out_t;

  // compact record from the parser front
  typedef struct packed {
    ccp_kind_t   kind;
    logic        entry_done;
    logic        pool_done;
    logic [15:0] entry_index;
    logic [7:0]  tag;
    logic [63:0] value;
    logic [7:0]  data;
    logic [31:0] total;
  } ccp_rec_t;

  // body length in bytes for a tag, zero for an unknown tag
  function automatic logic [3:0] body_len(input logic [7:0] tag);
    logic [3:0] len;
    len = 4'd0;
    if (tag == TAG_UTF8 || tag == TAG_CLASS || tag == TAG_STRING) begin
      len = 4'd2;
    end else if (tag == TAG_INTEGER || tag == TAG_FLOAT || tag == TAG_FIELDREF ||
                 tag == TAG_METHODREF || tag == TAG_IMETHREF || tag == TAG_NAMETYPE) begin
      len = 4'd4;
    end else if (tag == TAG_LONG || tag == TAG_DOUBLE) begin
      len = 4'd8;
    end
    return len;
  endfunction

endpackage

@@ rtl/ccp_front.sv @@
// ccp_front: byte-level parse state machine, emits one record per completed event
// depends on ccp_pkg
`timescale 1ns / 1ps

module ccp_front
  import ccp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     byte_valid,
  input  ccp_in_t  byte_in,
  output logic     rec_push,
  output ccp_rec_t rec
);

  ccp_phase_t  phase_r, phase_nxt;
  logic [3:0]  bif_r, bif_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [16:0] index_r, index_nxt;
  logic [15:0] decl_r, decl_nxt;
  logic [63:0] value_r, value_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [31:0] total_r, total_nxt;

  logic [7:0]  b;
  logic [31:0] total_inc;
  logic [16:0] index_step;
  logic        step_pool_done;

  assign b = byte_in.data_byte;

  // saturating byte count
  assign total_inc = (total_r == 32'hFFFF_FFFF) ? total_r : total_r + 32'd1;

  // index advance at entry completion, long and double take two slots
  assign index_step = index_r + ((tag_r == TAG_LONG || tag_r == TAG_DOUBLE) ? 17'd2 : 17'd1);
  assign step_pool_done = (index_step >= {1'b0, decl_r});

  // parse step
  always_comb begin
    phase_nxt = phase_r;
    bif_nxt   = bif_r;
    tag_nxt   = tag_r;
    index_nxt = index_r;
    decl_nxt  = decl_r;
    value_nxt = value_r;
    rem_nxt   = rem_r;
    total_nxt = total_r;
    rec_push  = 1'b0;
    rec       = '0;
    rec.kind  = REC_POOL;
    if (byte_valid) begin
      if (byte_in.start_of_pool) begin
        total_nxt = 32'd1;
        decl_nxt  = {b, 8'h00};
        index_nxt = 17'd1;
        bif_nxt   = 4'd0;
        tag_nxt   = 8'd0;
        value_nxt = '0;
        rem_nxt   = 16'd0;
        phase_nxt = PH_COUNT;
      end else begin
        unique case (phase_r)
          PH_COUNT: begin
            total_nxt = total_inc;
            decl_nxt  = {decl_r[15:8], b};
            if (decl_nxt <= 16'd1) begin
              rec_push      = 1'b1;
              rec.kind      = REC_POOL;
              rec.pool_done = 1'b1;
              rec.total     = total_inc;
              phase_nxt     = PH_DONE;
            end else begin
              phase_nxt = PH_TAG;
            end
          end
          PH_TAG: begin
            total_nxt = total_inc;
            tag_nxt   = b;
            bif_nxt   = 4'd0;
            value_nxt = '0;
            if (body_len(b) == 4'd0) begin
              rec_push        = 1'b1;
              rec.kind        = REC_BAD;
              rec.entry_index = index_r[15:0];
              rec.tag         = b;
              rec.total       = total_inc;
              phase_nxt       = PH_HALT;
            end else begin
              phase_nxt = PH_BODY;
            end
          end
          PH_BODY: begin
            total_nxt = total_inc;
            value_nxt = {value_r[55:0], b};
            bif_nxt   = bif_r + 4'd1;
            if (bif_nxt >= body_len(tag_r)) begin
              if (tag_r == TAG_UTF8 && value_nxt[15:0] != 16'd0) begin
                rem_nxt   = value_nxt[15:0];
                phase_nxt = PH_TEXT;
              end else begin
                if (tag_r == TAG_UTF8) begin
                  rem_nxt = 16'd0;
                end
                rec_push        = 1'b1;
                rec.kind        = REC_ENTRY;
                rec.entry_done  = 1'b1;
                rec.pool_done   = step_pool_done;
                rec.entry_index = index_r[15:0];
                rec.tag         = tag_r;
                rec.value       = value_nxt;
                rec.total       = total_inc;
                index_nxt       = index_step;
                phase_nxt       = step_pool_done ? PH_DONE : PH_TAG;
              end
            end
          end
          PH_TEXT: begin
            total_nxt       = total_inc;
            rem_nxt         = rem_r - 16'd1;
            rec_push        = 1'b1;
            rec.kind        = REC_TEXT;
            rec.entry_index = index_r[15:0];
            rec.tag         = tag_r;
            rec.value       = value_r;
            rec.data        = b;
            rec.total       = total_inc;
            if (rem_nxt == 16'd0) begin
              rec.entry_done = 1'b1;
              rec.pool_done  = step_pool_done;
              index_nxt      = index_step;
              phase_nxt      = step_pool_done ? PH_DONE : PH_TAG;
            end
          end
          default: begin
            // idle, done or halted: byte is dropped uncounted
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bif_r   <= 4'd0;
      tag_r   <= 8'd0;
      index_r <= 17'd1;
      decl_r  <= 16'd0;
      value_r <= '0;
      rem_r   <= 16'd0;
      total_r <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      bif_r   <= bif_nxt;
      tag_r   <= tag_nxt;
      index_r <= index_nxt;
      decl_r  <= decl_nxt;
      value_r <= value_nxt;
      rem_r   <= rem_nxt;
      total_r <= total_nxt;
    end
  end

  // a bad tag halts the parser
  a_bad_halts: assert property (@(posedge clk) disable iff (!rst_n)
    rec_push && rec.kind == REC_BAD |=> phase_r == PH_HALT)
    else $error("bad tag record without halt");

  // pool completion parks the parser in done
  a_pool_done: assert property (@(posedge clk) disable iff (!rst_n)
    rec_push && rec.pool_done |=> phase_r == PH_DONE)
    else $error("pool done record without done phase");

  // a text record only comes from the text phase
  a_text_phase: assert property (@(posedge clk) disable iff (!rst_n)
    rec_push && rec.kind == REC_TEXT |-> phase_r == PH_TEXT)
    else $error("text record outside text phase");

endmodule

@@ rtl/ccp_queue.sv @@
// ccp_queue: short record queue between parser front and result back end
// depends on ccp_pkg
`timescale 1ns / 1ps

module ccp_queue
  import ccp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ccp_rec_t push_data,
  output logic     full,
  input  logic     pop,
  output ccp_rec_t pop_data,
  output logic     empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  ccp_rec_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue occupancy out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> wr_ptr_r == rd_ptr_r)
    else $error("empty queue with pointer gap");

endmodule

@@ rtl/ccp_back.sv @@
// ccp_back: expands parser records into result items and holds the output register
// depends on ccp_pkg
`timescale 1ns / 1ps

module ccp_back
  import ccp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     rec_empty,
  input  ccp_rec_t rec,
  output logic     rec_pop,
  output logic     out_empty,
  input  logic     out_pop,
  output ccp_out_t out_data
);

  logic     out_valid_r;
  ccp_out_t out_data_r, res;

  // load when the output register is free or being drained
  assign rec_pop   = !rec_empty && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

  // format one result from a record
  always_comb begin
    res                = '0;
    res.bytes_consumed = rec.total;
    res.pool_done      = rec.pool_done;
    unique case (rec.kind)
      REC_POOL: begin
        // empty pool, only the flag and the count
      end
      REC_BAD: begin
        res.entry_index = rec.entry_index;
        res.tag_code    = rec.tag;
        res.bad_tag     = 1'b1;
      end
      REC_ENTRY: begin
        res.entry_done  = 1'b1;
        res.entry_index = rec.entry_index;
        res.tag_code    = rec.tag;
        if (rec.tag >= TAG_INTEGER && rec.tag <= TAG_DOUBLE) begin
          res.const_value = rec.value;
        end else if (rec.tag == TAG_CLASS || rec.tag == TAG_STRING) begin
          res.first_ref = rec.value[15:0];
        end else if (rec.tag >= TAG_FIELDREF && rec.tag <= TAG_NAMETYPE) begin
          res.first_ref  = rec.value[31:16];
          res.second_ref = rec.value[15:0];
        end
      end
      REC_TEXT: begin
        res.entry_done  = rec.entry_done;
        res.entry_index = rec.entry_index;
        res.tag_code    = rec.tag;
        res.first_ref   = rec.value[15:0];
        res.text_valid  = 1'b1;
        res.text_byte   = rec.data;
      end
      default: begin
      end
    endcase
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rec_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (rec_pop) begin
      out_data_r <= res;
    end
  end

endmodule

@@ rtl/class_constant_pool_parser.sv @@
// class_constant_pool_parser: a result passes through the record queue and the output register after its byte transfer
// throughput is one byte per cycle while full is low, set by the combinational parse step in ccp_front
// full rises only when the record queue between parser and output stage fills up
// synchronous active-low reset returns the parser to idle and empties both sides
`timescale 1ns / 1ps

module class_constant_pool_parser
  import ccp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  ccp_in_t  in_data,
  output logic     empty,
  input  logic     pop,
  output ccp_out_t out_data
);

  logic     accept;
  logic     rec_push, rec_pop, q_full, q_empty;
  ccp_rec_t rec_in, rec_out;

  assign full   = q_full;
  assign accept = push && !q_full;

  // byte parser
  ccp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (accept),
    .byte_in    (in_data),
    .rec_push   (rec_push),
    .rec        (rec_in)
  );

  // record queue
  ccp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .push_data (rec_in),
    .full      (q_full),
    .pop       (rec_pop),
    .pop_data  (rec_out),
    .empty     (q_empty)
  );

  // result formatter and output register
  ccp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_empty (q_empty),
    .rec       (rec_out),
    .rec_pop   (rec_pop),
    .out_empty (empty),
    .out_pop   (pop),
    .out_data  (out_data)
  );

endmodule

@@ tb/class_constant_pool_parser_test.sv @@
// class_constant_pool_parser_test: self-checking testbench for the constant pool parser
// drives byte items through the push/full queue port and checks every popped result
// depends on ccp_pkg and class_constant_pool_parser
`timescale 1ns / 1ps

module class_constant_pool_parser_test;
  import ccp_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int MAX_REPORTS  = 10;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     push = 1'b0;
  logic     full;
  ccp_in_t  in_data = '0;
  logic     empty;
  logic     pop = 1'b0;
  ccp_out_t out_data;

  class_constant_pool_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // parser shadow state
  ccp_phase_t  phase       = PH_IDLE;
  logic [3:0]  field_count = '0;
  logic [7:0]  tag_r       = '0;
  logic [16:0] slot_index  = 17'd1;
  logic [15:0] pool_count  = '0;
  logic [63:0] shift_reg   = '0;
  logic [15:0] text_left   = '0;
  logic [31:0] consumed    = '0;

  ccp_out_t parsed_due[$];
  int       mismatches    = 0;
  int       live_items    = 0;
  int       checked_count = 0;

  // sender and receiver pacing
  int burst_left   = 0;
  bit steady_send  = 1'b0;
  int rx_mode      = 0;
  int hold_request = 0;
  int hold_left    = 0;
  int cycle_no     = 0;

  // bytes of body that follow a tag, zero when the tag is unknown
  function automatic int tag_body_bytes(input logic [7:0] tag);
    unique case (tag)
      TAG_UTF8, TAG_CLASS, TAG_STRING: return 2;
      TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
      TAG_IMETHREF, TAG_NAMETYPE: return 4;
      TAG_LONG, TAG_DOUBLE: return 8;
      default: return 0;
    endcase
  endfunction

  // entry completion: index, tag, slot advance and end of pool
  function automatic void close_entry(inout ccp_out_t res);
    res.entry_done  = 1'b1;
    res.entry_index = slot_index[15:0];
    res.tag_code    = tag_r;
    slot_index = slot_index + ((tag_r == TAG_LONG || tag_r == TAG_DOUBLE) ? 17'd2 : 17'd1);
    if (slot_index >= {1'b0, pool_count}) begin
      res.pool_done = 1'b1;
      phase = PH_DONE;
    end else begin
      phase = PH_TAG;
    end
  endfunction

  // advance the shadow parser by one byte, queue any decoded result
  // returns 0 when the byte is ignored
  function automatic bit decode_byte(input ccp_in_t item);
    ccp_out_t   res;
    logic [7:0] b;
    bit         has_res;
    b       = item.data_byte;
    res     = '0;
    has_res = 1'b0;
    if (item.start_of_pool) begin
      consumed    = 32'd1;
      pool_count  = {b, 8'h00};
      slot_index  = 17'd1;
      field_count = '0;
      tag_r       = '0;
      shift_reg   = '0;
      text_left   = '0;
      phase       = PH_COUNT;
      return 1'b1;
    end
    if (phase == PH_IDLE || phase == PH_DONE || phase == PH_HALT) return 1'b0;
    if (consumed != 32'hFFFF_FFFF) consumed = consumed + 32'd1;
    unique case (phase)
      PH_COUNT: begin
        pool_count = pool_count | {8'h00, b};
        if (pool_count <= 16'd1) begin
          res.pool_done = 1'b1;
          has_res = 1'b1;
          phase = PH_DONE;
        end else begin
          phase = PH_TAG;
        end
      end
      PH_TAG: begin
        tag_r       = b;
        field_count = '0;
        shift_reg   = '0;
        if (tag_body_bytes(b) == 0) begin
          res.entry_index = slot_index[15:0];
          res.tag_code    = b;
          res.bad_tag     = 1'b1;
          has_res = 1'b1;
          phase = PH_HALT;
        end else begin
          phase = PH_BODY;
        end
      end
      PH_BODY: begin
        shift_reg   = {shift_reg[55:0], b};
        field_count = field_count + 4'd1;
        if (field_count >= tag_body_bytes(tag_r)) begin
          if (tag_r == TAG_UTF8) begin
            text_left = shift_reg[15:0];
            if (text_left != 16'd0) begin
              phase = PH_TEXT;
            end else begin
              has_res = 1'b1;
              close_entry(res);
            end
          end else begin
            has_res = 1'b1;
            if (tag_r == TAG_INTEGER || tag_r == TAG_FLOAT ||
                tag_r == TAG_LONG || tag_r == TAG_DOUBLE) begin
              res.const_value = shift_reg;
            end else if (tag_r == TAG_CLASS || tag_r == TAG_STRING) begin
              res.first_ref = shift_reg[15:0];
            end else begin
              res.first_ref  = shift_reg[31:16];
              res.second_ref = shift_reg[15:0];
            end
            close_entry(res);
          end
        end
      end
      PH_TEXT: begin
        has_res = 1'b1;
        res.first_ref  = shift_reg[15:0];
        res.text_valid = 1'b1;
        res.text_byte  = b;
        text_left = text_left - 16'd1;
        if (text_left == 16'd0) begin
          close_entry(res);
        end else begin
          res.entry_index = slot_index[15:0];
          res.tag_code    = tag_r;
        end
      end
      default: ;
    endcase
    if (has_res) begin
      res.bytes_consumed = consumed;
      parsed_due.push_back(res);
    end
    return 1'b1;
  endfunction

  // offer one byte in bursts with random gaps, predict once transferred
  task automatic send_byte(input logic [7:0] b, input logic s);
    ccp_in_t item;
    int      gap;
    item.data_byte     = b;
    item.start_of_pool = s;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = steady_send ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push    <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (full) @(posedge clk);
    if (decode_byte(item)) live_items++;
  endtask

  task automatic send_count(input logic [15:0] n);
    send_byte(n[15:8], 1'b1);
    send_byte(n[7:0], 1'b0);
  endtask

  // big-endian field of n bytes
  task automatic send_value(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) send_byte(v[8*i +: 8], 1'b0);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch at result %0d: %s expected %h got %h",
                 checked_count, name, want, got);
    end
  endtask

  task automatic check_result(input ccp_out_t got);
    ccp_out_t want;
    if (parsed_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected result %0d: %h", checked_count, got);
    end else begin
      want = parsed_due.pop_front();
      check_field("entry_done", 64'(want.entry_done), 64'(got.entry_done));
      check_field("entry_index", 64'(want.entry_index), 64'(got.entry_index));
      check_field("tag_code", 64'(want.tag_code), 64'(got.tag_code));
      check_field("const_value", want.const_value, got.const_value);
      check_field("first_ref", 64'(want.first_ref), 64'(got.first_ref));
      check_field("second_ref", 64'(want.second_ref), 64'(got.second_ref));
      check_field("text_valid", 64'(want.text_valid), 64'(got.text_valid));
      check_field("text_byte", 64'(want.text_byte), 64'(got.text_byte));
      check_field("pool_done", 64'(want.pool_done), 64'(got.pool_done));
      check_field("bytes_consumed", 64'(want.bytes_consumed), 64'(got.bytes_consumed));
      check_field("bad_tag", 64'(want.bad_tag), 64'(got.bad_tag));
    end
    checked_count++;
  endtask

  // result side: check each transfer, then pick the next pop from the stall pattern
  always @(posedge clk) begin
    if (pop && !empty) check_result(out_data);
    cycle_no++;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      unique case (rx_mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 3) != 0);
        2: pop <= ((cycle_no % 7) >= 3);
        default: pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // stray byte while idle, empty pools and a byte after done
  task automatic test_tiny_pools();
    rx_mode = 0;
    send_byte(8'hA5, 1'b0);
    send_count(16'd0);
    send_byte(8'hFF, 1'b0);
    send_count(16'd1);
  endtask

  // one entry of every tag, ending on an empty utf8 string
  task automatic test_every_tag();
    rx_mode = 1;
    send_count(16'd15);
    send_byte(TAG_UTF8, 1'b0);
    send_value(64'd2, 2);
    send_value(64'h6869, 2);
    send_byte(TAG_INTEGER, 1'b0);
    send_value(64'hFFFF_FFFF, 4);
    send_byte(TAG_FLOAT, 1'b0);
    send_value(64'h0, 4);
    send_byte(TAG_LONG, 1'b0);
    send_value(64'h8000_0000_0000_0001, 8);
    send_byte(TAG_DOUBLE, 1'b0);
    send_value(64'h7FF0_1234_5678_9ABC, 8);
    send_byte(TAG_CLASS, 1'b0);
    send_value(64'hFFFF, 2);
    send_byte(TAG_STRING, 1'b0);
    send_value(64'h0000, 2);
    send_byte(TAG_FIELDREF, 1'b0);
    send_value(64'h0001_FFFE, 4);
    send_byte(TAG_METHODREF, 1'b0);
    send_value(64'hA5A5_5A5A, 4);
    send_byte(TAG_IMETHREF, 1'b0);
    send_value(64'h0F0F_F0F0, 4);
    send_byte(TAG_NAMETYPE, 1'b0);
    send_value(64'hFFFF_0000, 4);
    send_byte(TAG_UTF8, 1'b0);
    send_value(64'd0, 2);
  endtask

  // double in the last slot runs past the count
  task automatic test_wide_last_slot();
    rx_mode = 2;
    send_count(16'd2);
    send_byte(TAG_DOUBLE, 1'b0);
    send_value(64'hFFFF_FFFF_FFFF_FFFF, 8);
  endtask

  // unknown tags halt, bytes while halted are dropped, start mid-parse restarts
  task automatic test_bad_tag_and_restart();
    rx_mode = 3;
    send_count(16'hFFFF);
    send_byte(TAG_CLASS, 1'b0);
    send_value(64'h0102, 2);
    send_byte(8'd2, 1'b0);
    send_byte(TAG_CLASS, 1'b0);
    send_count(16'd3);
    send_byte(8'hFF, 1'b0);
    send_count(16'd5);
    send_byte(TAG_INTEGER, 1'b0);
    send_value(64'hDEAD, 2);
    send_count(16'd2);
    send_byte(8'h00, 1'b0);
  endtask

  // long receiver hold while a text entry keeps the sender busy
  task automatic test_backpressure();
    steady_send = 1'b1;
    rx_mode = 0;
    hold_request = 300;
    send_count(16'd2);
    send_byte(TAG_UTF8, 1'b0);
    send_value(64'd40, 2);
    repeat (40) send_byte(8'($urandom_range(0, 255)), 1'b0);
    steady_send = 1'b0;
  endtask

  // one random pool, mostly well formed, sometimes cut short or broken
  task automatic send_random_pool();
    int         count;
    int         slots;
    int         choice;
    int         len;
    logic [7:0] tag;
    choice = $urandom_range(0, 99);
    if (choice < 5) count = $urandom_range(0, 1);
    else if (choice < 12) count = $urandom_range(15, 65535);
    else count = $urandom_range(2, 14);
    send_count(count[15:0]);
    slots = 1;
    while (slots < count) begin
      choice = $urandom_range(0, 99);
      if (count > 14 && slots > 6) break;
      if (choice < 3) begin
        do tag = 8'($urandom_range(0, 255)); while (tag_body_bytes(tag) != 0);
        send_byte(tag, 1'b0);
        break;
      end
      do tag = 8'($urandom_range(1, 12)); while (tag_body_bytes(tag) == 0);
      send_byte(tag, 1'b0);
      if (choice < 6) begin
        // truncated entry, the next start drops it
        repeat ($urandom_range(0, tag_body_bytes(tag) - 1))
          send_byte(8'($urandom_range(0, 255)), 1'b0);
        break;
      end
      if (tag == TAG_UTF8) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        send_value(64'(len), 2);
        repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_value({$urandom, $urandom}, tag_body_bytes(tag));
      end
      slots += (tag == TAG_LONG || tag == TAG_DOUBLE) ? 2 : 1;
    end
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic test_random_pools();
    int target;
    target = live_items + RANDOM_ITEMS;
    while (live_items < target) begin
      if ($urandom_range(0, 3) == 0) begin
        rx_mode = $urandom_range(0, 3);
        steady_send = ($urandom_range(0, 3) == 0);
      end
      send_random_pool();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_tiny_pools();
    test_every_tag();
    test_wide_last_slot();
    test_bad_tag_and_restart();
    test_backpressure();
    test_random_pools();
    push <= 1'b0;
    rx_mode = 0;
    while (parsed_due.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
